### sv/vld_pkg.sv
// Package for the varint length deframer: result kinds, widths and the result record.
// Depends on nothing; every other file of the block imports it.
package vld_pkg;

	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned LEN_W         = 31;
	localparam int unsigned PREFIX_W      = 32;
	localparam int unsigned KIND_W        = 2;
	localparam int unsigned CNT_W         = 3;
	localparam int unsigned ADDR_W        = 2;
	localparam int unsigned DATA_W        = 32;
	localparam int unsigned PREFIX_BYTES  = 5;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 31'd2097151;

	localparam logic [ADDR_W-1:0] REG_LEN_LIMIT = 2'd0;

	localparam logic [KIND_W-1:0] KIND_BODY      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EMPTY     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BAD_LEN   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LONG_PFX  = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] body_byte;
		logic              frame_end;
		logic [LEN_W-1:0]  frame_len;
	} res_t;

endpackage

### sv/vld_cfg.sv
// Configuration register file of the deframer, reached through an APB-style port.
// Depends on vld_pkg for the register map and widths.
module vld_cfg
	import vld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [LEN_W-1:0]  len_limit
);

	logic [LEN_W-1:0] max_len_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (psel && penable && pwrite && paddr == REG_LEN_LIMIT) begin
			max_len_q <= pwdata[LEN_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr)
			REG_LEN_LIMIT: prdata = {{(DATA_W-LEN_W){1'b0}}, max_len_q};
			default:       prdata = '0;
		endcase
	end

	assign len_limit = max_len_q;

endmodule

### sv/vld_parse.sv
// Input register and frame parser: decodes the varint prefix and walks the frame body.
// Depends on vld_pkg for the result record and kind codes.
module vld_parse
	import vld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [LEN_W-1:0]  len_limit,
	input  logic              out_free,
	output logic              step_load,
	output res_t              step_out
);

	logic                byte_valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                in_body_q;
	logic [PREFIX_W-1:0] prefix_q;
	logic [CNT_W-1:0]    count_q;
	logic [LEN_W-1:0]    left_q;
	logic [LEN_W-1:0]    total_q;

	logic                step_res;
	logic                advance;
	logic                accept;
	logic [PREFIX_W-1:0] part;
	logic [PREFIX_W-1:0] prefix_n;
	logic                restart;
	logic                enter_body;

	always_comb begin
		part = '0;
		case (count_q)
			3'd0:    part = {25'd0, byte_s1[6:0]};
			3'd1:    part = {18'd0, byte_s1[6:0], 7'd0};
			3'd2:    part = {11'd0, byte_s1[6:0], 14'd0};
			3'd3:    part = {4'd0, byte_s1[6:0], 21'd0};
			3'd4:    part = {byte_s1[3:0], 28'd0};
			default: part = '0;
		endcase
		prefix_n = prefix_q | part;
	end

	always_comb begin
		step_res   = 1'b0;
		step_out   = '0;
		restart    = 1'b0;
		enter_body = 1'b0;
		if (in_body_q) begin
			step_res           = 1'b1;
			step_out.kind      = KIND_BODY;
			step_out.body_byte = byte_s1;
			step_out.frame_end = (left_q <= LEN_W'(1));
			step_out.frame_len = total_q;
			restart            = (left_q <= LEN_W'(1));
		end else if (count_q >= CNT_W'(PREFIX_BYTES)) begin
			step_res           = 1'b1;
			step_out.kind      = KIND_LONG_PFX;
			step_out.frame_end = 1'b1;
			restart            = 1'b1;
		end else if (!byte_s1[7]) begin
			if (prefix_n[PREFIX_W-1] || prefix_n[LEN_W-1:0] > len_limit) begin
				step_res           = 1'b1;
				step_out.kind      = KIND_BAD_LEN;
				step_out.frame_end = 1'b1;
				restart            = 1'b1;
			end else if (prefix_n == '0) begin
				step_res           = 1'b1;
				step_out.kind      = KIND_EMPTY;
				step_out.frame_end = 1'b1;
				restart            = 1'b1;
			end else begin
				enter_body = 1'b1;
			end
		end
	end

	assign advance   = byte_valid_s1 && (!step_res || out_free);
	assign rx_stall  = byte_valid_s1 && !advance;
	assign accept    = rx_valid && !rx_stall;
	assign step_load = advance && step_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (accept) begin
			byte_valid_s1 <= 1'b1;
		end else if (advance) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			prefix_q  <= '0;
			count_q   <= '0;
			left_q    <= '0;
			total_q   <= '0;
		end else if (advance) begin
			if (restart) begin
				in_body_q <= 1'b0;
				prefix_q  <= '0;
				count_q   <= '0;
				left_q    <= '0;
				total_q   <= '0;
			end else if (in_body_q) begin
				left_q <= left_q - LEN_W'(1);
			end else if (enter_body) begin
				in_body_q <= 1'b1;
				left_q    <= prefix_n[LEN_W-1:0];
				total_q   <= prefix_n[LEN_W-1:0];
				prefix_q  <= '0;
				count_q   <= '0;
			end else begin
				prefix_q <= prefix_n;
				count_q  <= count_q + CNT_W'(1);
			end
		end
	end

endmodule

### sv/vld_outreg.sv
// Result register of the deframer, holding one request until the consumer takes it.
// Depends on vld_pkg for the result record.
module vld_outreg
	import vld_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t load_data,
	output logic free,
	output logic res_valid,
	input  logic res_stall,
	output res_t res_data
);

	logic valid_q;
	res_t data_q;

	assign free      = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign res_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

### sv/varint_length_deframer_core.sv
// Top level of the varint length deframer: configuration port, parser and result register.
// Depends on vld_pkg, vld_cfg, vld_parse and vld_outreg.
//
// The block takes one received byte per clock and splits the stream into frames, each
// opened by a little-endian base-128 length prefix of up to five bytes. It sustains one
// byte per cycle while the result port is not stalled; a byte is held in the input
// register, decoded there combinationally and written to the result register when that
// register is free; each result thus passes the input and then the result register.
// Prefix bytes that complete nothing yield no
// request. Body bytes come out with kind zero, and the last one has frame_end set; an
// empty frame, an out-of-range length and an over-long prefix each give one request with
// frame_end set. The maximum body length register should be written only while idle.
module varint_length_deframer_core
	import vld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [KIND_W-1:0] kind,
	output logic [BYTE_W-1:0] body_byte,
	output logic              frame_end,
	output logic [LEN_W-1:0]  frame_len
);

	logic [LEN_W-1:0] len_limit;
	logic             out_free;
	logic             step_load;
	res_t             step_out;
	res_t             res_data;

	vld_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.len_limit (len_limit)
	);

	vld_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.len_limit (len_limit),
		.out_free  (out_free),
		.step_load (step_load),
		.step_out  (step_out)
	);

	vld_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step_load),
		.load_data (step_out),
		.free      (out_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	assign kind      = res_data.kind;
	assign body_byte = res_data.body_byte;
	assign frame_end = res_data.frame_end;
	assign frame_len = res_data.frame_len;

endmodule

### verif/tb_varint_length_deframer_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for varint_length_deframer_core: a directed table, then random frames.
// Needs vld_pkg and the deframer RTL; results are checked against an in-bench predictor.
module tb_varint_length_deframer_core;
	import vld_pkg::*;

	localparam int LIMIT_CYCLES = 300000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 4;
	localparam int N_DIRECTED   = 26;

	typedef struct packed {
		logic [BYTE_W-1:0] rx;
		logic              fixed;
		logic              has_res;
		res_t              res;
	} dir_row_t;

	localparam res_t NO_RES = '0;
	localparam res_t EMPTY_RES = '{KIND_EMPTY, 8'h00, 1'b1, 31'd0};
	localparam res_t BAD_LEN_RES = '{KIND_BAD_LEN, 8'h00, 1'b1, 31'd0};
	localparam res_t LONG_PFX_RES = '{KIND_LONG_PFX, 8'h00, 1'b1, 31'd0};

	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{8'h00, 1'b1, 1'b1, EMPTY_RES},
		'{8'h01, 1'b1, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b1, '{KIND_BODY, 8'hFF, 1'b1, 31'd1}},
		'{8'h02, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h80, 1'b0, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES},
		'{8'h7F, 1'b1, 1'b1, LONG_PFX_RES},
		'{8'hFF, 1'b1, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b0, NO_RES},
		'{8'h0F, 1'b1, 1'b1, BAD_LEN_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES},
		'{8'h01, 1'b1, 1'b1, BAD_LEN_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES},
		'{8'h70, 1'b1, 1'b1, EMPTY_RES}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              rx_valid = 1'b0;
	logic              rx_stall;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic              res_valid;
	logic              res_stall;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] body_byte;
	logic              frame_end;
	logic [LEN_W-1:0]  frame_len;

	logic [LEN_W-1:0]    max_len_reg = MAX_LEN_RESET;
	logic                in_frame_body = 1'b0;
	logic [PREFIX_W-1:0] len_acc = '0;
	logic [CNT_W-1:0]    len_bytes = '0;
	logic [LEN_W-1:0]    body_left = '0;
	logic [LEN_W-1:0]    frame_total = '0;

	res_t pending_results [$];
	int   errors = 0;
	int   sent_items = 0;
	int   cycles = 0;
	bit   tx_idle_en = 1'b1;
	bit   rx_idle_en = 1'b1;
	bit   hold_req = 1'b0;

	varint_length_deframer_core DUT (.*);

	always #5 clk = ~clk;

	function automatic void clear_frame();
		in_frame_body = 1'b0;
		len_acc = '0;
		len_bytes = '0;
		body_left = '0;
		frame_total = '0;
	endfunction

	function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output res_t r);
		logic [63:0] part;
		r = '0;
		if (in_frame_body) begin
			if (body_left != 0)
				body_left--;
			r.kind = KIND_BODY;
			r.body_byte = b;
			r.frame_end = (body_left == 0);
			r.frame_len = frame_total;
			if (r.frame_end)
				clear_frame();
			return 1'b1;
		end
		if (len_bytes >= PREFIX_BYTES) begin
			r = LONG_PFX_RES;
			clear_frame();
			return 1'b1;
		end
		part = 64'(b[6:0]) << (7 * len_bytes);
		len_acc |= part[31:0];
		len_bytes++;
		if (b[7])
			return 1'b0;
		if (len_acc[31] || len_acc[LEN_W-1:0] > max_len_reg) begin
			r = BAD_LEN_RES;
			clear_frame();
			return 1'b1;
		end
		if (len_acc == 0) begin
			r = EMPTY_RES;
			clear_frame();
			return 1'b1;
		end
		in_frame_body = 1'b1;
		body_left = len_acc[LEN_W-1:0];
		frame_total = len_acc[LEN_W-1:0];
		len_acc = '0;
		len_bytes = '0;
		return 1'b0;
	endfunction

	// Called at a falling edge; returns at the falling edge after the byte is taken.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit fixed = 1'b0,
			input bit fixed_has = 1'b0, input res_t fixed_res = '0);
		res_t r;
		bit   has;
		if (tx_idle_en && $urandom_range(99) < 12) begin
			rx_valid <= 1'b0;
			rx_byte <= 8'($urandom);
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
		has = deframe_byte(b, r);
		if (fixed) begin
			has = fixed_has;
			r = fixed_res;
		end
		if (has)
			pending_results.push_back(r);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic send_len(input logic [31:0] v);
		int n;
		logic [BYTE_W-1:0] b;
		n = 1;
		while (n < 5 && (v >> (7 * n)) != 0)
			n++;
		if ($urandom_range(3) == 0)
			n = $urandom_range(5, n);
		for (int i = 0; i < n; i++) begin
			b = {1'b0, 7'(v >> (7 * i))};
			if (i == 4)
				b[6:4] = 3'($urandom);
			b[7] = (i < n - 1);
			send_byte(b);
		end
	endtask

	task automatic send_frame();
		int pick;
		int cap;
		int len;
		logic [31:0] v;
		logic [BYTE_W-1:0] b;
		pick = $urandom_range(99);
		if (pick < 70) begin
			cap = (max_len_reg < 24) ? int'(max_len_reg) : 24;
			len = $urandom_range(cap, 0);
			if (max_len_reg <= 64 && $urandom_range(3) == 0)
				len = int'(max_len_reg);
			send_len(32'(len));
			repeat (len) send_byte(8'($urandom));
		end else if (pick < 82) begin
			if (max_len_reg == '1) begin
				v = {1'b1, 31'($urandom)};
			end else begin
				v = $urandom;
				if (!v[31] && v[LEN_W-1:0] <= max_len_reg)
					v = {1'b0, max_len_reg} + 32'd1 + 32'($urandom_range(3));
			end
			send_len(v);
		end else if (pick < 92) begin
			repeat (PREFIX_BYTES) send_byte(8'h80 | 8'($urandom_range(127)));
			send_byte(8'($urandom));
		end else begin
			b = 8'($urandom);
			send_byte(b);
			if (b[7])
				send_byte(8'($urandom_range(3)));
			while (in_frame_body)
				send_byte(8'($urandom));
		end
	endtask

	task automatic drain();
		rx_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_max_len(input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= REG_LEN_LIMIT;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		max_len_reg = value[LEN_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				res_stall <= 1'b1;
			end else begin
				res_stall <= rx_idle_en && ($urandom_range(99) < 20);
			end
		end
	end

	always @(posedge clk) begin
		res_t exp_res;
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected request kind %0d byte %02h end %0b len %0d",
						$realtime, kind, body_byte, frame_end, frame_len);
			end else begin
				exp_res = pending_results.pop_front();
				if (kind !== exp_res.kind || body_byte !== exp_res.body_byte ||
						frame_end !== exp_res.frame_end ||
						frame_len !== exp_res.frame_len) begin
					errors++;
					if (errors <= 10) begin
						$write("%0t: exp/got kind %0d/%0d byte %02h/%02h ",
							$realtime, exp_res.kind, kind, exp_res.body_byte, body_byte);
						$display("end %0b/%0b len %0d/%0d", exp_res.frame_end, frame_end,
							exp_res.frame_len, frame_len);
					end
				end
			end
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_byte(DIRECTED[i].rx, DIRECTED[i].fixed, DIRECTED[i].has_res,
				DIRECTED[i].res);
		drain();

		// The receiver holds off while a long frame streams in, so the block backs up.
		hold_req = 1'b1;
		send_len(32'd60);
		repeat (60) send_byte(8'($urandom));
		while (sent_items < 180)
			send_frame();
		drain();

		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		write_max_len(32'd0);
		while (sent_items < 260)
			send_frame();
		drain();

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		write_max_len(32'hFFFF_FFFF);
		while (sent_items < 320)
			send_frame();
		drain();
		while (sent_items < 400)
			send_frame();
		drain();

		write_max_len(32'($urandom_range(40, 1)));
		while (sent_items < 530)
			send_frame();
		drain();

		repeat (10) @(negedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### filelist.f
sv/vld_pkg.sv
sv/vld_cfg.sv
sv/vld_parse.sv
sv/vld_outreg.sv
sv/varint_length_deframer_core.sv
verif/tb_varint_length_deframer_core.sv
